[hdl/hcbp_pkg.sv]
package hcbp_pkg;

    // Table geometry and code limits.
    localparam int MAX_CODE_LEN = 32;
    localparam int SYMBOL_COUNT = 256;
    localparam int CODE_W       = 32;
    localparam int LEN_W        = 6;
    localparam int SYM_W        = 8;
    localparam int ADDR_W       = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
    localparam int ENTRY_W      = CODE_W + LEN_W;

    // Longest length that a stored entry may carry.
    localparam int CODE_CAP     = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;

    // The accumulator holds up to seven waiting bits plus one whole code.
    localparam int PEND_W       = 7;
    localparam int ACC_W        = PEND_W + CODE_W;

    // Operation codes carried by an input item.
    typedef enum logic [1:0] {
        OP_LOAD   = 2'd0,
        OP_ENCODE = 2'd1,
        OP_END    = 2'd2
    } op_t;

endpackage

[hdl/huffman_code_bit_packer.sv]
// Huffman code bit packer. A load item (operation 0) writes one entry of a
// code table held in a single-port synchronous RAM of 256 entries, each a
// code of up to 32 bits with the first bit sent at position length minus one;
// it gives no result. An encode item (operation 1) reads the entry of its
// symbol and appends the code to a byte accumulator, and an end item
// (operation 2) appends the code of symbol 0 and then pads any leftover bits
// with zeros at the low end into one last byte flagged stream_done. Each item
// is accepted, then its table entry is read, and then its result bytes leave
// one per cycle while the output is not stalled (at most five bytes), followed
// by a closing pass through the emit state unless the item finishes on a padded
// byte. A load item needs no table read. Only one item is in flight at a time,
// set by the read-modify sequence on the table RAM and the accumulator. Table
// entries have no reset: encoding a symbol that was never loaded gives
// undefined bytes.
module huffman_code_bit_packer (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [1:0]                  operation,
    input  logic [hcbp_pkg::SYM_W-1:0]  symbol,
    input  logic [hcbp_pkg::CODE_W-1:0] code_bits,
    input  logic [hcbp_pkg::LEN_W-1:0]  code_length,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [7:0]                  out_byte,
    output logic                        last_in_run,
    output logic                        stream_done
);
    import hcbp_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_EMIT
    } state_t;

    state_t              state_reg;
    logic [ACC_W-1:0]    acc_reg;
    logic [LEN_W-1:0]    cnt_reg;
    logic                is_end_reg;
    logic                sym_ok_reg;
    logic                out_valid_reg;
    logic [7:0]          out_byte_reg;
    logic                last_reg;
    logic                done_reg;

    logic [ENTRY_W-1:0]  code_table [SYMBOL_COUNT];
    logic [ENTRY_W-1:0]  rd_data_reg;

    logic                in_take;
    op_t                 op;
    logic                sym_in_range;
    logic [ADDR_W-1:0]   rd_addr;
    logic                rd_en;
    logic                wr_en;
    logic [LEN_W-1:0]    len_sat;
    logic [CODE_W-1:0]   code_masked;
    logic                slot_free;
    logic                emit_fire;

    logic [LEN_W-1:0]    entry_len;
    logic [CODE_W-1:0]   entry_code;
    logic [PEND_W-1:0]   pend_bits;
    logic [ACC_W-1:0]    acc_next;
    logic [LEN_W-1:0]    cnt_next;
    logic [ACC_W-1:0]    acc_shifted;
    logic [7:0]          full_byte;
    logic [7:0]          pad_byte;

    // Input handshake: one item at a time.
    assign in_stall = (state_reg != ST_IDLE);
    assign in_take  = in_valid && !in_stall;
    assign op       = op_t'(operation);

    assign sym_in_range = ({1'b0, symbol} < 9'(SYMBOL_COUNT));

    // Saturate the length and drop code bits above it on load.
    assign len_sat     = (code_length > LEN_W'(CODE_CAP)) ? LEN_W'(CODE_CAP) : code_length;
    assign code_masked = code_bits & CODE_W'((33'd1 << len_sat) - 33'd1);

    // Table access decode.
    always_comb
    begin
        wr_en   = 1'b0;
        rd_en   = 1'b0;
        rd_addr = ADDR_W'(symbol);
        unique case (op)
            OP_LOAD:
            begin
                wr_en = in_take && sym_in_range;
            end
            OP_ENCODE:
            begin
                rd_en = in_take;
            end
            OP_END:
            begin
                rd_en   = in_take;
                rd_addr = '0;
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    // Code table RAM: one write or one read per cycle, registered read data.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            code_table[rd_addr] <= {len_sat, code_masked};
        end
        if (rd_en)
        begin
            rd_data_reg <= code_table[rd_addr];
        end
    end

    // Merge the waiting bits with the code that was read.
    assign entry_len   = sym_ok_reg ? rd_data_reg[ENTRY_W-1:CODE_W] : '0;
    assign entry_code  = sym_ok_reg ? rd_data_reg[CODE_W-1:0] : '0;
    assign pend_bits   = acc_reg[PEND_W-1:0] & PEND_W'((8'd1 << cnt_reg[2:0]) - 8'd1);
    assign acc_next    = (ACC_W'(pend_bits) << entry_len) | ACC_W'(entry_code);
    assign cnt_next    = LEN_W'(cnt_reg[2:0]) + entry_len;

    // Byte extraction: the oldest eight bits, or the leftover padded with zeros.
    assign acc_shifted = acc_reg >> (cnt_reg - LEN_W'(8));
    assign full_byte   = acc_shifted[7:0];
    assign pad_byte    = 8'(pend_bits) << (4'd8 - {1'b0, cnt_reg[2:0]});

    assign slot_free = !out_valid_reg || !out_stall;

    // A byte is loaded into the output register in this cycle.
    assign emit_fire = (state_reg == ST_EMIT) && slot_free &&
                       ((cnt_reg >= LEN_W'(8)) || (is_end_reg && (cnt_reg != '0)));

    // Sequencer, accumulator and output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            acc_reg       <= '0;
            cnt_reg       <= '0;
            is_end_reg    <= 1'b0;
            sym_ok_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            out_byte_reg  <= '0;
            last_reg      <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && !out_stall && !emit_fire)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (rd_en)
                    begin
                        is_end_reg <= (op == OP_END);
                        sym_ok_reg <= (op == OP_END) || sym_in_range;
                        state_reg  <= ST_LOOKUP;
                    end
                end
                ST_LOOKUP:
                begin
                    acc_reg   <= acc_next;
                    cnt_reg   <= cnt_next;
                    state_reg <= ST_EMIT;
                end
                ST_EMIT:
                begin
                    if (cnt_reg >= LEN_W'(8))
                    begin
                        if (slot_free)
                        begin
                            out_valid_reg <= 1'b1;
                            out_byte_reg  <= full_byte;
                            last_reg      <= is_end_reg ? (cnt_reg == LEN_W'(8))
                                                        : (cnt_reg < LEN_W'(16));
                            done_reg      <= is_end_reg && (cnt_reg == LEN_W'(8));
                            cnt_reg       <= cnt_reg - LEN_W'(8);
                        end
                    end
                    else if (is_end_reg && (cnt_reg != '0))
                    begin
                        if (slot_free)
                        begin
                            out_valid_reg <= 1'b1;
                            out_byte_reg  <= pad_byte;
                            last_reg      <= 1'b1;
                            done_reg      <= 1'b1;
                            cnt_reg       <= '0;
                            state_reg     <= ST_IDLE;
                        end
                    end
                    else
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_byte    = out_byte_reg;
    assign last_in_run = last_reg;
    assign stream_done = done_reg;

endmodule

[tb/sv/huffman_code_bit_packer_tb.sv]
`timescale 1ns / 100ps

module huffman_code_bit_packer_tb;

    import hcbp_pkg::*;

    localparam logic [1:0] OP_UNUSED    = 2'd3;
    localparam int         PLAN_ROWS    = 26;
    localparam int         RANDOM_ITEMS = 150;
    localparam int         IDLE_LIMIT   = 5000;
    localparam int         HOLD_CYCLES  = 80;
    localparam int         DRAIN_CYCLES = 20;

    // One packed output byte with its flags.
    typedef struct packed {
        logic [7:0] value;
        logic       last;
        logic       done;
    } out_rec_t;

    // One row of the directed stimulus; typed rows carry their own bytes.
    typedef struct packed {
        logic [1:0]       op;
        logic [7:0]       sym;
        logic [31:0]      code;
        logic [5:0]       len;
        logic             typed;
        logic [2:0]       count;
        logic [3:0][9:0]  want;
    } stim_row_t;

    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        in_valid    = 1'b0;
    logic        in_stall;
    logic [1:0]  operation   = 2'd0;
    logic [7:0]  symbol      = 8'd0;
    logic [31:0] code_bits   = 32'd0;
    logic [5:0]  code_length = 6'd0;
    logic        out_valid;
    logic        out_stall   = 1'b0;
    logic [7:0]  out_byte;
    logic        last_in_run;
    logic        stream_done;

    // Predicted copy of the code book and the bit accumulator.
    logic [31:0] book_code [SYMBOL_COUNT];
    logic [5:0]  book_len  [SYMBOL_COUNT];
    logic [6:0]  acc_bits  = '0;
    logic [2:0]  acc_count = '0;
    bit          sym_known [SYMBOL_COUNT];
    logic [7:0]  known_syms [$];

    out_rec_t    fresh [$];
    out_rec_t    due_bytes [$];

    int          mismatches = 0;
    int          got_count  = 0;
    int          idle_count = 0;
    int          hold_left  = 0;
    bit          held       = 1'b0;
    bit          quiet      = 1'b0;

    // Directed items: extremes of code and length, ignored operation and the
    // end-of-stream variants with and without leftover bits.
    stim_row_t plan [PLAN_ROWS] = '{
        '{OP_LOAD,   8'd0,   32'h0000_00A5, 6'd8,  1'b1, 3'd0, 40'h0},
        '{OP_ENCODE, 8'd0,   32'h0,         6'd0,  1'b1, 3'd1,
          {30'h0, 8'hA5, 2'b10}},
        '{OP_LOAD,   8'd255, 32'hFFFF_FFFF, 6'd32, 1'b1, 3'd0, 40'h0},
        '{OP_ENCODE, 8'd255, 32'h0,         6'd0,  1'b1, 3'd4,
          {8'hFF, 2'b10, 8'hFF, 2'b00, 8'hFF, 2'b00, 8'hFF, 2'b00}},
        '{OP_LOAD,   8'd1,   32'hDEAD_BEEF, 6'd0,  1'b1, 3'd0, 40'h0},
        '{OP_ENCODE, 8'd1,   32'h0,         6'd0,  1'b1, 3'd0, 40'h0},
        '{OP_LOAD,   8'd2,   32'hFFFF_FFFF, 6'd63, 1'b1, 3'd0, 40'h0},
        '{OP_ENCODE, 8'd2,   32'h0,         6'd0,  1'b1, 3'd4,
          {8'hFF, 2'b10, 8'hFF, 2'b00, 8'hFF, 2'b00, 8'hFF, 2'b00}},
        '{OP_LOAD,   8'd3,   32'hFFFF_FFFE, 6'd3,  1'b1, 3'd0, 40'h0},
        '{OP_ENCODE, 8'd3,   32'h0,         6'd0,  1'b1, 3'd0, 40'h0},
        '{OP_END,    8'd0,   32'h0,         6'd0,  1'b1, 3'd2,
          {20'h0, 8'hA0, 2'b11, 8'hD4, 2'b00}},
        '{OP_END,    8'd0,   32'h0,         6'd0,  1'b1, 3'd1,
          {30'h0, 8'hA5, 2'b11}},
        '{OP_LOAD,   8'd0,   32'hFFFF_FFFF, 6'd0,  1'b1, 3'd0, 40'h0},
        '{OP_END,    8'd0,   32'h0,         6'd0,  1'b1, 3'd0, 40'h0},
        '{OP_UNUSED, 8'd5,   32'h1234_5678, 6'd20, 1'b1, 3'd0, 40'h0},
        '{OP_ENCODE, 8'd3,   32'h0,         6'd0,  1'b1, 3'd0, 40'h0},
        '{OP_END,    8'd0,   32'h0,         6'd0,  1'b1, 3'd1,
          {30'h0, 8'hC0, 2'b11}},
        '{OP_LOAD,   8'd128, 32'h0000_0155, 6'd9,  1'b0, 3'd0, 40'h0},
        '{OP_LOAD,   8'd127, 32'h5555_5555, 6'd31, 1'b0, 3'd0, 40'h0},
        '{OP_ENCODE, 8'd128, 32'hFFFF_FFFF, 6'd63, 1'b0, 3'd0, 40'h0},
        '{OP_ENCODE, 8'd127, 32'h0,         6'd0,  1'b0, 3'd0, 40'h0},
        '{OP_LOAD,   8'd0,   32'hFFFF_FFFE, 6'd2,  1'b0, 3'd0, 40'h0},
        '{OP_END,    8'd0,   32'h0,         6'd0,  1'b0, 3'd0, 40'h0},
        '{OP_LOAD,   8'd4,   32'h0000_0000, 6'd32, 1'b0, 3'd0, 40'h0},
        '{OP_ENCODE, 8'd4,   32'h0,         6'd0,  1'b0, 3'd0, 40'h0},
        '{OP_END,    8'd0,   32'h0,         6'd0,  1'b0, 3'd0, 40'h0}
    };

    huffman_code_bit_packer dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .operation   (operation),
        .symbol      (symbol),
        .code_bits   (code_bits),
        .code_length (code_length),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_byte    (out_byte),
        .last_in_run (last_in_run),
        .stream_done (stream_done)
    );

    // Free-running clock, 10 ns period.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Shift the code of one table entry into the accumulator, first bit first.
    task automatic shift_code(input logic [7:0] sym);
        logic [31:0] code;
        int          n;
        code = book_code[sym];
        n    = book_len[sym];
        for (int i = n; i > 0; i--)
        begin
            if (acc_count == 3'd7)
            begin
                fresh = {fresh, out_rec_t'({acc_bits, code[i-1], 2'b00})};
                acc_bits  = '0;
                acc_count = '0;
            end
            else
            begin
                acc_bits  = {acc_bits[5:0], code[i-1]};
                acc_count = acc_count + 3'd1;
            end
        end
    endtask

    // Work out the bytes that one item produces and update the predicted state.
    task automatic pack_item(input logic [1:0] op, input logic [7:0] sym,
                             input logic [31:0] code, input logic [5:0] len);
        logic [5:0] cap;
        logic [7:0] tail;
        out_rec_t   rec;
        fresh.delete();
        case (op)
            OP_LOAD:
            begin
                cap = (len > CODE_CAP) ? 6'(CODE_CAP) : len;
                book_len[sym]  = cap;
                book_code[sym] = (cap >= 6'd32) ? code : (code & ((32'd1 << cap) - 32'd1));
                if (!sym_known[sym])
                begin
                    sym_known[sym] = 1'b1;
                    known_syms = {known_syms, sym};
                end
            end
            OP_ENCODE:
            begin
                shift_code(sym);
            end
            OP_END:
            begin
                shift_code(8'd0);
                if (acc_count != 3'd0)
                begin
                    tail = {1'b0, acc_bits} << (8 - acc_count);
                    fresh = {fresh, out_rec_t'({tail, 2'b00})};
                    acc_bits  = '0;
                    acc_count = '0;
                end
            end
            default:
            begin
            end
        endcase
        // Flag the final byte of this item, and of the stream on an end item.
        if (fresh.size() > 0 && (op == OP_ENCODE || op == OP_END))
        begin
            rec      = fresh.pop_back();
            rec.last = 1'b1;
            rec.done = (op == OP_END);
            fresh = {fresh, rec};
        end
    endtask

    // Offer one item, wait for it to be taken, then queue what it should give.
    task automatic run_item(input logic [1:0] op, input logic [7:0] sym,
                            input logic [31:0] code, input logic [5:0] len,
                            input logic typed, input int count,
                            input logic [3:0][9:0] want);
        @(negedge clk);
        if (!quiet && $urandom_range(99) < 14)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(negedge clk);
        end
        in_valid    <= 1'b1;
        operation   <= op;
        symbol      <= sym;
        code_bits   <= code;
        code_length <= len;
        do @(posedge clk); while (in_stall !== 1'b0);
        pack_item(op, sym, code, len);
        if (typed)
        begin
            for (int i = 0; i < count; i++)
                due_bytes = {due_bytes, out_rec_t'(want[i])};
        end
        else
        begin
            foreach (fresh[i])
                due_bytes = {due_bytes, fresh[i]};
        end
    endtask

    // Receiver: random stalls, one long hold-off, and a calm stretch.
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left = hold_left - 1;
        end
        else if (!held && got_count >= 40)
        begin
            held      = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= (!quiet && $urandom_range(99) < 14);
        end
    end

    // Compare each byte taken with the oldest one still due.
    always @(posedge clk)
    begin
        out_rec_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            got_count = got_count + 1;
            if (due_bytes.size() == 0)
            begin
                mismatches = mismatches + 1;
                $display("%0t: unexpected byte %h last %b done %b", $time,
                         out_byte, last_in_run, stream_done);
            end
            else
            begin
                want = due_bytes.pop_front();
                if (out_byte !== want.value || last_in_run !== want.last ||
                    stream_done !== want.done)
                begin
                    mismatches = mismatches + 1;
                    $display("%0t: expected byte %h last %b done %b, got byte %h last %b done %b",
                             $time, want.value, want.last, want.done,
                             out_byte, last_in_run, stream_done);
                end
            end
        end
    end

    // Watchdog on cycles in which neither side moves an item.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_count = 0;
        else
            idle_count = idle_count + 1;
        if (idle_count >= IDLE_LIMIT)
        begin
            $display("huffman_code_bit_packer test failed");
            $finish;
        end
    end

    // Main sequence: reset, directed table, random items, drain and verdict.
    initial
    begin
        logic [1:0]  op;
        logic [7:0]  sym;
        logic [31:0] code;
        logic [5:0]  len;
        int          pick;
        int          k;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (plan[r])
            run_item(plan[r].op, plan[r].sym, plan[r].code, plan[r].len,
                     plan[r].typed, plan[r].count, plan[r].want);

        // Mostly encodes of loaded symbols, with reloads, ends and some noise.
        k = 0;
        while (k < RANDOM_ITEMS)
        begin
            quiet = (k >= 60 && k < 100);
            pick  = $urandom_range(99);
            code  = $urandom;
            len   = 6'($urandom_range(63));
            if (pick < 4)
            begin
                op  = OP_UNUSED;
                sym = 8'($urandom_range(255));
            end
            else
            begin
                k = k + 1;
                if (pick < 18)
                begin
                    op   = OP_LOAD;
                    sym  = 8'($urandom_range(255));
                    pick = $urandom_range(99);
                    if (pick < 5)
                        len = 6'd0;
                    else if (pick < 70)
                        len = 6'($urandom_range(12, 1));
                    else if (pick < 90)
                        len = 6'($urandom_range(32, 13));
                    else
                        len = 6'($urandom_range(63, 33));
                end
                else if (pick < 26)
                begin
                    op  = OP_END;
                    sym = 8'($urandom_range(255));
                end
                else
                begin
                    op  = OP_ENCODE;
                    sym = known_syms[$urandom_range(known_syms.size() - 1)];
                end
            end
            run_item(op, sym, code, len, 1'b0, 0, 40'h0);
        end
        quiet = 1'b0;

        @(negedge clk);
        in_valid <= 1'b0;

        // Let every due byte arrive, then watch for stray ones.
        while (due_bytes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("huffman_code_bit_packer test passed");
        else
            $display("huffman_code_bit_packer test failed");
        $finish;
    end

endmodule
